// ----- rtl/rcd_pkg.sv -----
// Shared types and constants of the ring corner detector.
// Used by rcd_ring and ring_corner_detector; no dependencies.
`default_nettype none
package rcd_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_MAX_HEIGHT  = 1024;
	localparam int DEF_MAX_CORNERS = 64;

	localparam int LINE_ROWS = 6;
	localparam int WIN       = 7;
	localparam int RADIUS    = 3;
	localparam int RING_N    = 16;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CMP_W     = 13;
	localparam int MIN_SIZE  = 7;

	localparam int RING_DX [RING_N] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
	localparam int RING_DY [RING_N] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_THRESH   = 3'd2,
		REG_TOL      = 3'd3,
		REG_SUPPRESS = 3'd4
	} reg_idx_t;

	typedef logic [WIN-1:0][7:0] col_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [9:0]  corner_x;
		logic [9:0]  corner_y;
		logic [15:0] corner_count;
		logic        frame_done;
		logic        list_full;
	} out_t;

endpackage
`default_nettype wire

// ----- rtl/rcd_ring.sv -----
// 7x7 pixel window shift register and the 16-point ring test on its centre.
// Depends on rcd_pkg.
`default_nettype none
module rcd_ring import rcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       shift_en,
	input  wire col_t       col_in,
	input  wire logic [7:0] thresh,
	input  wire logic [4:0] tol,
	output logic            corner
);

	// win_q[a][r]: a = column age (0 newest), r = row (0 oldest)
	logic [WIN-1:0][WIN-1:0][7:0] win_q;
	logic [RING_N-1:0] dark, bright;
	logic [4:0] n_dark, n_bright, best;
	logic [7:0] centre;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= {win_q[WIN-2:0], col_in};
		end
	end

	assign centre = win_q[RADIUS][RADIUS];

	for (genvar i = 0; i < RING_N; i++) begin : g_pt
		logic [7:0] v;
		assign v         = win_q[RADIUS - RING_DX[i]][RING_DY[i] + RADIUS];
		assign dark[i]   = ({1'b0, v} + {1'b0, thresh}) < {1'b0, centre};
		assign bright[i] = !dark[i] && (({1'b0, centre} + {1'b0, thresh}) < {1'b0, v});
	end

	always_comb begin
		n_dark   = '0;
		n_bright = '0;
		for (int i = 0; i < RING_N; i++) begin
			n_dark   = n_dark + 5'(dark[i]);
			n_bright = n_bright + 5'(bright[i]);
		end
		best   = (n_bright > n_dark) ? n_bright : n_dark;
		corner = best >= tol;
	end

endmodule
`default_nettype wire

// ----- rtl/ring_corner_detector.sv -----
// Ring corner detector top level: line memory, corner list, control FSM.
// Depends on rcd_pkg and rcd_ring.
//
// Usage: pixels arrive in raster order on pix (pix_valid / pix_stall);
// frame_start on the first pixel of a frame clears position, corner list,
// count and the full flag. Results leave on res (res_valid / res_stall):
// one transaction per corner found, and one summary (frame_done = 1, total
// count) on the last pixel of each frame.
// Each pixel goes through line memory read, window shift with write-back,
// ring test and result. A centre that passes the ring test scans the stored
// corner list, one entry at a time in S_SCAN then S_CMP, through the single
// list memory read port; a new pixel is taken only back in S_IDLE.
// res_valid is set in S_DONE, after S_READ, S_EVAL and any list scan.
// A result sits in an output register; a stalled receiver holds it there and
// only blocks the block once a second result is ready to go out.
// Reset clears position, counters and configuration to defaults; the line
// and list memories are not cleared. Configuration is written on cfg_we.
`default_nettype none
module ring_corner_detector import rcd_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = DEF_MAX_HEIGHT,
	parameter int MAX_CORNERS = DEF_MAX_CORNERS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pix_valid,
	output logic                      pix_stall,
	input  wire in_t                  pix,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output out_t                      res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int PW = $clog2(MAX_WIDTH);
	localparam int PH = $clog2(MAX_HEIGHT);
	localparam int FW = $clog2(MAX_CORNERS + 1);
	localparam int LW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_EVAL = 6'b000100,
		S_SCAN = 6'b001000,
		S_CMP  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] width_q, height_q;
	logic [7:0]       thr_q;
	logic [4:0]       tol_q;
	logic [9:0]       sd_q;

	logic [PW-1:0] col_q;
	logic [PH-1:0] row_q;
	logic [2:0]    slot_q;
	logic [FW-1:0] fill_q, idx_q;
	logic [15:0]   total_q;
	logic          ovf_q;
	logic [7:0]    pix_q;
	logic          found_q;

	logic [LINE_ROWS*8-1:0] line_mem [MAX_WIDTH];
	logic [LINE_ROWS*8-1:0] line_rd_q;
	logic [19:0]            list_mem [MAX_CORNERS];
	logic [19:0]            list_rd_q;

	logic                  accept;
	logic [PW-1:0]         rd_col;
	col_t                  col_vec;
	logic [LINE_ROWS*8-1:0] wr_word;
	logic                  ring_hit;
	logic [CMP_W-1:0]      w_c, h_c, col_c, row_c, cx, cy, sx, sy, ax, ay;
	logic                  eligible, last, near, emit;

	assign accept    = pix_valid && !pix_stall;
	assign pix_stall = (state_q != S_IDLE);
	assign rd_col    = pix.frame_start ? '0 : col_q;

	// clamped geometry and comparisons at a common width
	always_comb begin
		w_c = CMP_W'(width_q);
		h_c = CMP_W'(height_q);
		if (w_c < CMP_W'(MIN_SIZE)) w_c = CMP_W'(MIN_SIZE);
		if (w_c > CMP_W'(MAX_WIDTH)) w_c = CMP_W'(MAX_WIDTH);
		if (h_c < CMP_W'(MIN_SIZE)) h_c = CMP_W'(MIN_SIZE);
		if (h_c > CMP_W'(MAX_HEIGHT)) h_c = CMP_W'(MAX_HEIGHT);
		col_c    = CMP_W'(col_q);
		row_c    = CMP_W'(row_q);
		cx       = col_c - CMP_W'(RADIUS);
		cy       = row_c - CMP_W'(RADIUS);
		eligible = (col_c >= CMP_W'(2*RADIUS)) && (row_c >= CMP_W'(2*RADIUS))
			&& (col_c < w_c) && (row_c < h_c);
		last     = (col_c >= w_c - 1'b1) && (row_c >= h_c - 1'b1);
		sx       = CMP_W'(list_rd_q[9:0]);
		sy       = CMP_W'(list_rd_q[19:10]);
		ax       = (cx > sx) ? cx - sx : sx - cx;
		ay       = (cy > sy) ? cy - sy : sy - cy;
		near     = (ax <= CMP_W'(sd_q)) && (ay <= CMP_W'(sd_q));
		emit     = last || found_q;
	end

	// column of the window: oldest row (slot being overwritten) first, new pixel last
	always_comb begin
		logic [3:0] s;
		for (int j = 0; j < LINE_ROWS; j++) begin
			s = 4'(slot_q) + 4'(j);
			if (s >= 4'(LINE_ROWS)) s = s - 4'(LINE_ROWS);
			col_vec[j] = line_rd_q[s*8 +: 8];
		end
		col_vec[WIN-1] = pix_q;
		wr_word = line_rd_q;
		wr_word[slot_q*8 +: 8] = pix_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_rd_q <= line_mem[rd_col];
		end
		if (state_q == S_READ) begin
			line_mem[col_q] <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			list_rd_q <= list_mem[idx_q[LW-1:0]];
		end
		if (state_q == S_DONE && found_q && fill_q < FW'(MAX_CORNERS)) begin
			list_mem[fill_q[LW-1:0]] <= {cy[9:0], cx[9:0]};
		end
	end

	rcd_ring u_ring (
		.clk      (clk),
		.shift_en (state_q == S_READ),
		.col_in   (col_vec),
		.thresh   (thr_q),
		.tol      (tol_q),
		.corner   (ring_hit)
	);

	always_ff @(posedge clk) begin
		if (accept) pix_q <= pix.pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
			thr_q    <= 8'd20;
			tol_q    <= 5'd12;
			sd_q     <= 10'd15;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:    width_q  <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_THRESH:   thr_q    <= cfg_data[7:0];
				REG_TOL:      tol_q    <= cfg_data[4:0];
				REG_SUPPRESS: sd_q     <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			slot_q    <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			total_q   <= '0;
			ovf_q     <= 1'b0;
			found_q   <= 1'b0;
			res_valid <= 1'b0;
			res       <= '0;
		end else begin
			// a result loaded in S_DONE takes the place of the one leaving
			if (res_valid && !res_stall && !(state_q == S_DONE && emit)) res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (pix.frame_start) begin
							col_q   <= '0;
							row_q   <= '0;
							slot_q  <= '0;
							fill_q  <= '0;
							total_q <= '0;
							ovf_q   <= 1'b0;
						end
						found_q <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					idx_q <= '0;
					if (eligible && ring_hit) begin
						if (fill_q == '0) begin
							found_q <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: state_q <= S_CMP;
				S_CMP: begin
					if (near) begin
						state_q <= S_DONE;
					end else if (idx_q + 1'b1 >= fill_q) begin
						found_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					if (!(emit && res_valid && res_stall)) begin
						logic [15:0] tot;
						logic        ovf;
						tot = total_q;
						ovf = ovf_q;
						if (found_q) begin
							if (fill_q < FW'(MAX_CORNERS)) fill_q <= fill_q + 1'b1;
							else ovf = 1'b1;
							if (total_q != 16'hFFFF) tot = total_q + 1'b1;
						end
						total_q <= tot;
						ovf_q   <= ovf;
						if (emit) begin
							res_valid         <= 1'b1;
							res.corner_x      <= last ? 10'd0 : cx[9:0];
							res.corner_y      <= last ? 10'd0 : cy[9:0];
							res.corner_count  <= tot;
							res.frame_done    <= last;
							res.list_full     <= ovf;
						end
						if (col_c >= w_c - 1'b1) begin
							col_q <= '0;
							if (last) begin
								row_q  <= '0;
								slot_q <= '0;
							end else begin
								row_q  <= row_q + 1'b1;
								slot_q <= (slot_q == 3'(LINE_ROWS - 1)) ? 3'd0 : slot_q + 1'b1;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_CORNERS))
		else $error("corner list fill past capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> fill_q == FW'(MAX_CORNERS))
		else $error("overflow flag set with room in list");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> idx_q < fill_q)
		else $error("list scan past fill");

endmodule
`default_nettype wire

// ----- tb/tb_ring_corner_detector.sv -----
// Self-checking testbench for ring_corner_detector: drives frames of pixels, some
// cut short; checks corners and frame summaries against an in-bench corner predictor.
// Depends on rcd_pkg and the ring_corner_detector RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_ring_corner_detector;
	import rcd_pkg::*;

	typedef enum int {PAT_NOISE, PAT_FLAT, PAT_DOTS, PAT_BLOCK, PAT_CHECK, PAT_BINARY} pattern_t;

	typedef struct {
		int       w, h, thr, tol, sup;
		pattern_t pat;
		int       lo, hi;
		bit       fs_first;
		bit       typed;
		int       tcount;
		bit       tfull;
	} frame_row_t;

	logic clk, arst_n;
	logic pix_valid, pix_stall, res_valid, res_stall;
	in_t  pix;
	out_t res;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int  err_count = 0;
	int  pix_sent = 0;
	bit  quiet = 0;
	out_t corner_q[$];

	// predictor state
	int cf_w, cf_h, cf_thr, cf_tol, cf_sup;
	byte unsigned line_mem [LINE_ROWS*1024];
	byte unsigned tail [5];
	int corner_xy [64][2];
	int fill, total, cpos, rpos;
	bit ovf;

	ring_corner_detector dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int clamp_dim(int v);
		if (v < MIN_SIZE) return MIN_SIZE;
		if (v > 1024) return 1024;
		return v;
	endfunction

	function automatic int win_pix(int dx, int dy, int col, int row);
		int k, r, c;
		if (dy == -RADIUS) begin
			k = RADIUS - dx;
			if (k < 0 || k > 4) return 0;
			return tail[k];
		end
		r = row + dy + RADIUS - 2*RADIUS;
		c = col + dx + RADIUS - 2*RADIUS;
		return line_mem[(r % LINE_ROWS)*1024 + (c % 1024)];
	endfunction

	function automatic bit near_corner(int cx, int cy);
		int ax, ay;
		for (int i = 0; i < fill; i++) begin
			ax = cx > corner_xy[i][0] ? cx - corner_xy[i][0] : corner_xy[i][0] - cx;
			ay = cy > corner_xy[i][1] ? cy - corner_xy[i][1] : corner_xy[i][1] - cy;
			if (ax <= cf_sup && ay <= cf_sup) return 1;
		end
		return 0;
	endfunction

	function automatic bit ring_pass(int col, int row);
		int centre, v, darker, brighter;
		centre = win_pix(0, 0, col, row);
		darker = 0;
		brighter = 0;
		for (int i = 0; i < RING_N; i++) begin
			v = win_pix(RING_DX[i], RING_DY[i], col, row);
			if (centre - cf_thr > v) darker++;
			else if (centre + cf_thr < v) brighter++;
		end
		return (brighter > darker ? brighter : darker) >= cf_tol;
	endfunction

	// advance the predictor by one pixel; hit says whether a result comes out
	function automatic void predict_corner(input logic [7:0] p, input logic fs,
			output bit hit, output out_t r);
		int w, h, col, row, slot, cx, cy;
		bit found, last;
		if (fs) begin
			cpos = 0; rpos = 0; fill = 0; total = 0; ovf = 0;
		end
		w = clamp_dim(cf_w);
		h = clamp_dim(cf_h);
		col = cpos % 1024;
		row = rpos;
		slot = (row % LINE_ROWS)*1024 + col;
		for (int k = 4; k > 0; k--) tail[k] = tail[k-1];
		tail[0] = line_mem[slot];
		line_mem[slot] = p;
		found = 0;
		cx = 0;
		cy = 0;
		if (col >= 2*RADIUS && row >= 2*RADIUS && col < w && row < h) begin
			cx = col - RADIUS;
			cy = row - RADIUS;
			if (!near_corner(cx, cy) && ring_pass(col, row)) begin
				found = 1;
				if (fill < 64) begin
					corner_xy[fill][0] = cx;
					corner_xy[fill][1] = cy;
					fill++;
				end else begin
					ovf = 1;
				end
				if (total < 65535) total++;
			end
		end
		last = (col >= w-1) && (row >= h-1);
		if (col >= w-1) begin
			cpos = 0;
			rpos = last ? 0 : row + 1;
		end else begin
			cpos = col + 1;
		end
		hit = last || found;
		r.corner_x = last ? 10'd0 : cx[9:0];
		r.corner_y = last ? 10'd0 : cy[9:0];
		r.corner_count = total[15:0];
		r.frame_done = last;
		r.list_full = ovf;
	endfunction

	task automatic write_reg(reg_idx_t idx, int val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			REG_WIDTH:    cf_w = val & 'h7FF;
			REG_HEIGHT:   cf_h = val & 'h7FF;
			REG_THRESH:   cf_thr = val & 'hFF;
			REG_TOL:      cf_tol = val & 'h1F;
			REG_SUPPRESS: cf_sup = val & 'h3FF;
			default: ;
		endcase
	endtask

	// wait until every expected result is out, then let the list scan drain
	task automatic drain();
		@(negedge clk);
		pix_valid = 0;
		while (corner_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [7:0] pixel_at(frame_row_t f, int x, int y);
		case (f.pat)
			PAT_FLAT:   return 8'(f.lo);
			PAT_DOTS:   return (x % 4 == 1 && y % 4 == 1) ? 8'(f.hi) : 8'(f.lo);
			PAT_BLOCK:  return (x >= f.w/2 && y >= f.h/2) ? 8'(f.hi) : 8'(f.lo);
			PAT_CHECK:  return ((x + y) & 1) ? 8'(f.hi) : 8'(f.lo);
			PAT_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_frame(frame_row_t f, int npix);
		int w, h, n;
		bit hit;
		out_t r;
		drain();
		write_reg(REG_WIDTH, f.w);
		write_reg(REG_HEIGHT, f.h);
		write_reg(REG_THRESH, f.thr);
		write_reg(REG_TOL, f.tol);
		write_reg(REG_SUPPRESS, f.sup);
		w = clamp_dim(f.w & 'h7FF);
		h = clamp_dim(f.h & 'h7FF);
		f.w = w;
		f.h = h;
		n = 0;
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				if (npix > 0 && n >= npix) return;
				@(negedge clk);
				if (!quiet && $urandom_range(0, 9) == 0) begin
					pix_valid = 0;
					repeat ($urandom_range(1, 19) - 1) @(negedge clk);
					@(negedge clk);
				end
				pix_valid = 1;
				pix.pixel = pixel_at(f, x, y);
				pix.frame_start = (n == 0) ? f.fs_first : 1'b0;
				do @(posedge clk); while (pix_stall);
				predict_corner(pix.pixel, pix.frame_start, hit, r);
				if (hit) begin
					if (r.frame_done && f.typed) begin
						r.corner_count = f.tcount[15:0];
						r.list_full = f.tfull;
					end
					corner_q = {corner_q, r};
				end
				n++;
				pix_sent++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (corner_q.size() == 0) begin
				$error("unexpected result transaction x=%0d y=%0d", res.corner_x, res.corner_y);
				err_count++;
			end else begin
				automatic out_t e = corner_q.pop_front();
				if (res.corner_x !== e.corner_x) begin
					$error("corner_x expected %0d actual %0d", e.corner_x, res.corner_x);
					err_count++;
				end
				if (res.corner_y !== e.corner_y) begin
					$error("corner_y expected %0d actual %0d", e.corner_y, res.corner_y);
					err_count++;
				end
				if (res.corner_count !== e.corner_count) begin
					$error("corner_count expected %0d actual %0d", e.corner_count,
						res.corner_count);
					err_count++;
				end
				if (res.frame_done !== e.frame_done) begin
					$error("frame_done expected %0d actual %0d", e.frame_done, res.frame_done);
					err_count++;
				end
				if (res.list_full !== e.list_full) begin
					$error("list_full expected %0d actual %0d", e.list_full, res.list_full);
					err_count++;
				end
			end
		end
	end

	// receiver back-pressure in random bursts
	initial begin
		res_stall = 0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				res_stall = 1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			res_stall = 0;
		end
	end

	initial begin
		frame_row_t dir_tbl [$];
		frame_row_t f;
		pix_valid = 0;
		pix = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		cf_w = 640; cf_h = 480; cf_thr = 20; cf_tol = 12; cf_sup = 15;
		fill = 0; total = 0; cpos = 0; rpos = 0; ovf = 0;
		foreach (line_mem[i]) line_mem[i] = 0;
		foreach (tail[i]) tail[i] = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// w, h, thr, tol, sup, pattern, lo, hi, fs, typed, count, full
		dir_tbl = '{
			'{7, 7, 20, 17, 15, PAT_NOISE, 0, 0, 1, 1, 0, 0},
			'{7, 7, 0, 0, 0, PAT_FLAT, 80, 80, 1, 1, 1, 0},
			'{17, 12, 0, 0, 0, PAT_FLAT, 0, 0, 1, 1, 66, 1},
			'{0, 0, 0, 0, 0, PAT_FLAT, 255, 255, 1, 1, 1, 0},
			'{7, 7, 255, 16, 0, PAT_DOTS, 0, 255, 1, 1, 0, 0},
			'{7, 7, 254, 16, 0, PAT_CHECK, 255, 255, 1, 0, 0, 0},
			'{8, 8, 0, 0, 1023, PAT_FLAT, 9, 9, 1, 1, 1, 0},
			'{9, 9, 10, 9, 0, PAT_DOTS, 10, 200, 1, 0, 0, 0},
			'{9, 9, 10, 9, 2, PAT_DOTS, 240, 5, 0, 0, 0, 0},
			'{10, 10, 30, 9, 3, PAT_BLOCK, 20, 220, 1, 0, 0, 0},
			'{8, 8, 0, 16, 0, PAT_CHECK, 0, 255, 1, 0, 0, 0},
			'{8, 8, 50, 31, 0, PAT_BINARY, 0, 0, 1, 1, 0, 0},
			'{2047, 7, 20, 17, 15, PAT_NOISE, 0, 0, 1, 1, 0, 0},
			'{7, 2047, 20, 17, 15, PAT_NOISE, 0, 0, 1, 1, 0, 0},
			'{1024, 1024, 20, 12, 15, PAT_NOISE, 0, 0, 1, 0, 0, 0}
		};
		// the last three rows start a frame that is then cut short
		foreach (dir_tbl[i]) run_frame(dir_tbl[i], (i >= dir_tbl.size()-3) ? 40 : 0);

		while (pix_sent < 1350) begin
			f.w = $urandom_range(0, 5) == 0 ? $urandom_range(0, 30) : $urandom_range(7, 16);
			f.h = $urandom_range(0, 5) == 0 ? $urandom_range(0, 14) : $urandom_range(7, 11);
			f.thr = $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) ? 255 : 0)
				: $urandom_range(0, 60);
			f.tol = $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(8, 13);
			f.sup = $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 4);
			f.pat = pattern_t'($urandom_range(0, 5));
			f.lo = $urandom_range(0, 255);
			f.hi = $urandom_range(0, 255);
			f.fs_first = $urandom_range(0, 7) != 0;
			f.typed = 0;
			f.tcount = 0;
			f.tfull = 0;
			if (pix_sent > 1150) quiet = 1;
			run_frame(f, $urandom_range(0, 9) == 0 ? $urandom_range(1, 60) : 0);
		end

		drain();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
`default_nettype wire
